// File: hw/rtl/dmtlb_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the direct-mapped tlb
// no dependencies

package dmtlb_pkg;

    localparam int NUM_ENTRIES    = 512;   // power of two, index is the low page bits
    localparam int PAGE_NUM_BITS  = 20;
    localparam int FRAME_NUM_BITS = 20;
    localparam int IDX_W          = $clog2(NUM_ENTRIES);
    localparam int CNT_W          = 32;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    typedef logic [IDX_W-1:0]          t_idx;
    typedef logic [PAGE_NUM_BITS-1:0]  t_page;
    typedef logic [FRAME_NUM_BITS-1:0] t_frame;
    typedef logic [CNT_W-1:0]          t_cnt;

    typedef struct packed {
        logic   valid;
        t_page  tag;
        t_frame frame;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_idx   idx;
        t_entry entry;
    } t_wr_req;

    typedef struct packed {
        logic lookup;
        logic hit;
    } t_cnt_evt;

    function automatic t_idx page_index(input t_page page);
        return page[IDX_W-1:0];
    endfunction

endpackage

// File: hw/rtl/dmtlb_entry_store.sv
`timescale 1ns / 1ps
// entry memory with registered read, write forwarding and the clearing pass
// depends on dmtlb_pkg

module dmtlb_entry_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  dmtlb_pkg::t_idx   i_rd_idx,
    input  dmtlb_pkg::t_wr_req i_wr,
    output dmtlb_pkg::t_entry o_entry,
    output logic              o_clearing
);
    import dmtlb_pkg::*;

    t_entry r_mem [NUM_ENTRIES];
    t_entry r_rd_data;
    t_idx   r_rd_idx;
    logic   r_byp_en;
    t_idx   r_byp_idx;
    t_entry r_byp_entry;
    logic   r_clr_active;
    t_idx   r_clr_idx;

    // memory port: clearing pass owns the write side until done
    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.entry;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
            r_rd_idx  <= i_rd_idx;
        end
    end

    // last write, for a read that raced it in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_en <= 1'b0;
        end else begin
            r_byp_en <= i_wr.en;
        end
        r_byp_idx   <= i_wr.idx;
        r_byp_entry <= i_wr.entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
        end else if (r_clr_active) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == IDX_W'(NUM_ENTRIES - 1)) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    assign o_entry    = (r_byp_en && r_byp_idx == r_rd_idx) ? r_byp_entry : r_rd_data;
    assign o_clearing = r_clr_active;

`ifndef ASSERT_OFF
    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !i_wr.en)
        else $error("entry write during clearing pass");
    a_no_read_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !i_rd_en)
        else $error("entry read during clearing pass");
    a_clear_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active && $past(r_clr_active) && $past(i_rst_n)
        |-> r_clr_idx == IDX_W'($past(r_clr_idx) + 1'b1))
        else $error("clearing pass skipped an entry");
`endif

endmodule

// File: hw/rtl/dmtlb_counters.sv
`timescale 1ns / 1ps
// wrapping lookup, hit and miss counters
// depends on dmtlb_pkg

module dmtlb_counters (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dmtlb_pkg::t_cnt_evt i_evt,
    output dmtlb_pkg::t_cnt     o_lookups,
    output dmtlb_pkg::t_cnt     o_hits,
    output dmtlb_pkg::t_cnt     o_misses
);
    import dmtlb_pkg::*;

    t_cnt r_lookups, n_lookups;
    t_cnt r_hits, n_hits;
    t_cnt r_misses, n_misses;

    always_comb begin
        n_lookups = r_lookups;
        n_hits    = r_hits;
        n_misses  = r_misses;
        if (i_evt.lookup) begin
            n_lookups = r_lookups + 1'b1;
            if (i_evt.hit) begin
                n_hits = r_hits + 1'b1;
            end else begin
                n_misses = r_misses + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookups <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
        end else begin
            r_lookups <= n_lookups;
            r_hits    <= n_hits;
            r_misses  <= n_misses;
        end
    end

    assign o_lookups = r_lookups;
    assign o_hits    = r_hits;
    assign o_misses  = r_misses;

endmodule

// File: hw/rtl/direct_mapped_tlb_core.sv
`timescale 1ns / 1ps
// direct-mapped tlb: lookup, insert and remove of virtual page numbers
// an accepted beat passes through the stage 1 register and the result register, then shows with o_valid
// throughput: one beat per cycle, back to back, while busy is low
// reset: counters cleared, then a clearing pass zeroes every entry, busy high
// results are strobed for one cycle; the receiver cannot stall
// depends on dmtlb_pkg, dmtlb_entry_store, dmtlb_counters

module direct_mapped_tlb_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             i_op,
    input  dmtlb_pkg::t_page       i_vpage,
    input  dmtlb_pkg::t_frame      i_frame,
    output logic                   o_valid,
    output logic                   o_hit,
    output dmtlb_pkg::t_frame      o_frame_out,
    output dmtlb_pkg::t_cnt        o_lookup_count,
    output dmtlb_pkg::t_cnt        o_hit_count,
    output dmtlb_pkg::t_cnt        o_miss_count
);
    import dmtlb_pkg::*;

    logic     accept;
    logic     clearing;

    // stage 1: request registered while the entry memory read is in flight
    logic     r_s1_valid;
    logic [1:0] r_s1_op;
    t_page    r_s1_vpage;
    t_frame   r_s1_frame;

    t_entry   entry;
    logic     match;
    t_wr_req  wr;
    t_cnt_evt evt;
    logic     n_hit;
    t_frame   n_frame_out;

    // result register
    logic     r_valid;
    logic     r_hit;
    t_frame   r_frame_out;

    assign busy   = clearing;
    assign accept = start && !clearing;

    dmtlb_entry_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_idx   (page_index(i_vpage)),
        .i_wr       (wr),
        .o_entry    (entry),
        .o_clearing (clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
        if (accept) begin
            r_s1_op    <= i_op;
            r_s1_vpage <= i_vpage;
            r_s1_frame <= i_frame;
        end
    end

    // tag compare on the entry read for this beat
    assign match = entry.valid && (entry.tag == r_s1_vpage);

    always_comb begin
        wr          = '0;
        wr.idx      = page_index(r_s1_vpage);
        evt         = '0;
        n_hit       = 1'b0;
        n_frame_out = '0;
        if (r_s1_valid) begin
            case (r_s1_op)
                OP_LOOKUP: begin
                    evt.lookup = 1'b1;
                    evt.hit    = match;
                    n_hit      = match;
                    if (match) begin
                        n_frame_out = entry.frame;
                    end
                end
                OP_INSERT: begin
                    wr.en          = 1'b1;
                    wr.entry.valid = 1'b1;
                    wr.entry.tag   = r_s1_vpage;
                    wr.entry.frame = r_s1_frame;
                end
                OP_REMOVE: begin
                    // a matching entry goes back to all zero
                    wr.en = match;
                    n_hit = match;
                end
                default: begin
                    // unused op code: no state change, empty result
                end
            endcase
        end
    end

    // counters move on the same edge as the result, so they read as after this beat
    dmtlb_counters u_counters (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_evt     (evt),
        .o_lookups (o_lookup_count),
        .o_hits    (o_hit_count),
        .o_misses  (o_miss_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_s1_valid;
        end
        r_hit       <= n_hit;
        r_frame_out <= n_frame_out;
    end

    assign o_valid     = r_valid;
    assign o_hit       = r_hit;
    assign o_frame_out = r_frame_out;

`ifndef ASSERT_OFF
    a_counts_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(o_hit_count + o_miss_count) == o_lookup_count)
        else $error("hit and miss counts do not add up to lookups");
    a_lookup_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_op == OP_LOOKUP
        |=> o_lookup_count == CNT_W'($past(o_lookup_count) + 1'b1))
        else $error("lookup beat not counted");
    a_insert_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_op == OP_INSERT |=> o_valid && !o_hit && o_frame_out == '0)
        else $error("insert beat reported a hit or a frame");
`endif

endmodule
